### hw/rtl/bgt_pkg.sv
// Shared types and constants for the button and touch gesture tracker.
`timescale 1ns / 1ps

package bgt_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SETTLE_MS        = 3'd0,
        CFG_LONG_PRESS_MS    = 3'd1,
        CFG_TAP_SPAN_PX      = 3'd2,
        CFG_SWIPE_REACH_PX   = 3'd3,
        CFG_RELEASE_QUIET_MS = 3'd4,
        CFG_SWIPE_MAX_MS     = 3'd5,
        CFG_TAP_MAX_MS       = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;

    // touch report kinds; code 3 is unused and acts as no report
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_POINT    = 2'd1,
        KIND_NOFINGER = 2'd2
    } t_touch_kind;

    typedef enum logic [1:0] {
        GEST_NONE        = 2'd0,
        GEST_TAP         = 2'd1,
        GEST_SWIPE_LEFT  = 2'd2,
        GEST_SWIPE_RIGHT = 2'd3
    } t_gesture;

    typedef struct packed {
        logic [15:0] settle_ms;
        logic [15:0] long_press_ms;
        logic [11:0] tap_span_px;
        logic [11:0] swipe_reach_px;
        logic [15:0] release_quiet_ms;
        logic [15:0] swipe_max_ms;
        logic [15:0] tap_max_ms;
    } t_cfg;

    localparam logic [15:0] RST_SETTLE_MS        = 16'd40;
    localparam logic [15:0] RST_LONG_PRESS_MS    = 16'd800;
    localparam logic [11:0] RST_TAP_SPAN_PX      = 12'd24;
    localparam logic [11:0] RST_SWIPE_REACH_PX   = 12'd56;
    localparam logic [15:0] RST_RELEASE_QUIET_MS = 16'd120;
    localparam logic [15:0] RST_SWIPE_MAX_MS     = 16'd900;
    localparam logic [15:0] RST_TAP_MAX_MS       = 16'd600;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic button_down;
    } t_btn_res;

    typedef struct packed {
        logic     touch_began;
        logic     touch_ended;
        t_gesture gesture;
        logic     finger_present;
    } t_touch_flags;

endpackage

### hw/rtl/bgt_in_if.sv
// Poll tick input channel: valid/ready plus one poll item.
`timescale 1ns / 1ps

interface bgt_in_if #(
    parameter int COORD_WIDTH = 12
);
    logic                   valid;
    logic                   ready;
    logic [31:0]            now_ms;
    logic                   button_level;
    logic [1:0]             touch_kind;
    logic [COORD_WIDTH-1:0] touch_x;
    logic [COORD_WIDTH-1:0] touch_y;

    modport source (
        output valid, now_ms, button_level, touch_kind, touch_x, touch_y,
        input  ready
    );
    modport sink (
        input  valid, now_ms, button_level, touch_kind, touch_x, touch_y,
        output ready
    );
endinterface

### hw/rtl/bgt_out_if.sv
// Result channel: valid/ready plus one result item.
`timescale 1ns / 1ps

interface bgt_out_if #(
    parameter int COORD_WIDTH = 12
);
    logic                   valid;
    logic                   ready;
    logic                   short_press;
    logic                   long_press;
    logic                   button_down;
    logic                   touch_began;
    logic                   touch_ended;
    logic [1:0]             gesture;
    logic                   finger_present;
    logic [COORD_WIDTH-1:0] cur_x;
    logic [COORD_WIDTH-1:0] cur_y;
    logic [COORD_WIDTH-1:0] origin_x;
    logic [COORD_WIDTH-1:0] origin_y;
    logic [31:0]            hold_ms;

    modport source (
        output valid, short_press, long_press, button_down, touch_began, touch_ended,
               gesture, finger_present, cur_x, cur_y, origin_x, origin_y, hold_ms,
        input  ready
    );
    modport sink (
        input  valid, short_press, long_press, button_down, touch_began, touch_ended,
               gesture, finger_present, cur_x, cur_y, origin_x, origin_y, hold_ms,
        output ready
    );
endinterface

### hw/rtl/button_and_touch_gesture_tracker.sv
// Top level of the button and touch gesture tracker.
//
//   channel   | direction | handshake      | item
//   ----------+-----------+----------------+------------------------------------------
//   i_in      | in        | valid / ready  | now_ms, button_level, touch_kind, x, y
//   o_res     | out       | valid / ready  | press flags, touch flags, gesture, points,
//             |           |                | hold_ms
//   i_cfg_*   | in        | write enable   | register index, 16-bit data
//
// One item per clock sustained while results are taken. An item waits in the
// input register, where the button and touch state is read and its next value
// computed, and moves to the result register when that one is free or being
// taken. The state update happens on that move, so the next item sees it.
// Synchronous active-low reset clears the pipeline valids, tracking state
// and loads the register defaults. A stalled result holds; the input register
// still fills behind it, and the input side stalls only when both are full.
`timescale 1ns / 1ps

module button_and_touch_gesture_tracker #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bgt_in_if.sink                         i_in,
    bgt_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [bgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    bgt_pkg::t_cfg cfg;

    // input register
    logic                       r_in_valid;
    logic [bgt_pkg::TIME_W-1:0] r_now;
    logic                       r_level;
    logic [1:0]                 r_kind;
    logic [COORD_WIDTH-1:0]     r_x, r_y;

    // result register
    logic                       r_out_valid;
    bgt_pkg::t_btn_res          r_btn;
    bgt_pkg::t_touch_flags      r_tflags;
    logic [COORD_WIDTH-1:0]     r_cur_x, r_cur_y, r_org_x, r_org_y;
    logic [bgt_pkg::TIME_W-1:0] r_hold;

    bgt_pkg::t_btn_res          btn_res;
    bgt_pkg::t_touch_flags      tflags;
    logic [COORD_WIDTH-1:0]     cur_x, cur_y, org_x, org_y;
    logic [bgt_pkg::TIME_W-1:0] hold;

    logic adv;      // input item moves to the result register
    logic in_take;  // new item enters the input register

    assign adv     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || adv;

    bgt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bgt_button u_button (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_now   (r_now),
        .i_level (r_level),
        .i_cfg   (cfg),
        .o_res   (btn_res)
    );

    bgt_touch #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_touch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_now     (r_now),
        .i_kind    (r_kind),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_cfg     (cfg),
        .o_flags   (tflags),
        .o_cur_x   (cur_x),
        .o_cur_y   (cur_y),
        .o_org_x   (org_x),
        .o_org_y   (org_y),
        .o_hold_ms (hold)
    );

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= i_in.now_ms;
            r_level <= i_in.button_level;
            r_kind  <= i_in.touch_kind;
            r_x     <= i_in.touch_x;
            r_y     <= i_in.touch_y;
        end
        if (adv) begin
            r_btn    <= btn_res;
            r_tflags <= tflags;
            r_cur_x  <= cur_x;
            r_cur_y  <= cur_y;
            r_org_x  <= org_x;
            r_org_y  <= org_y;
            r_hold   <= hold;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.short_press    = r_btn.short_press;
    assign o_res.long_press     = r_btn.long_press;
    assign o_res.button_down    = r_btn.button_down;
    assign o_res.touch_began    = r_tflags.touch_began;
    assign o_res.touch_ended    = r_tflags.touch_ended;
    assign o_res.gesture        = r_tflags.gesture;
    assign o_res.finger_present = r_tflags.finger_present;
    assign o_res.cur_x          = r_cur_x;
    assign o_res.cur_y          = r_cur_y;
    assign o_res.origin_x       = r_org_x;
    assign o_res.origin_y       = r_org_y;
    assign o_res.hold_ms        = r_hold;
endmodule

### hw/rtl/bgt_cfg_regs.sv
// Configuration register bank with reset defaults.
`timescale 1ns / 1ps

module bgt_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bgt_pkg::t_cfg                o_cfg
);
    bgt_pkg::t_cfg r_cfg;
    bgt_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bgt_pkg::CFG_SETTLE_MS:        n_cfg.settle_ms        = i_cfg_data;
                bgt_pkg::CFG_LONG_PRESS_MS:    n_cfg.long_press_ms    = i_cfg_data;
                bgt_pkg::CFG_TAP_SPAN_PX:      n_cfg.tap_span_px      = i_cfg_data[11:0];
                bgt_pkg::CFG_SWIPE_REACH_PX:   n_cfg.swipe_reach_px   = i_cfg_data[11:0];
                bgt_pkg::CFG_RELEASE_QUIET_MS: n_cfg.release_quiet_ms = i_cfg_data;
                bgt_pkg::CFG_SWIPE_MAX_MS:     n_cfg.swipe_max_ms     = i_cfg_data;
                bgt_pkg::CFG_TAP_MAX_MS:       n_cfg.tap_max_ms       = i_cfg_data;
                default:                       n_cfg = r_cfg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms        <= bgt_pkg::RST_SETTLE_MS;
            r_cfg.long_press_ms    <= bgt_pkg::RST_LONG_PRESS_MS;
            r_cfg.tap_span_px      <= bgt_pkg::RST_TAP_SPAN_PX;
            r_cfg.swipe_reach_px   <= bgt_pkg::RST_SWIPE_REACH_PX;
            r_cfg.release_quiet_ms <= bgt_pkg::RST_RELEASE_QUIET_MS;
            r_cfg.swipe_max_ms     <= bgt_pkg::RST_SWIPE_MAX_MS;
            r_cfg.tap_max_ms       <= bgt_pkg::RST_TAP_MAX_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

### hw/rtl/bgt_button.sv
// Button debounce by edge time, short and long press detection.
`timescale 1ns / 1ps

module bgt_button (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,      // commit the item in the input register
    input  logic [bgt_pkg::TIME_W-1:0]    i_now,
    input  logic                          i_level,
    input  bgt_pkg::t_cfg                 i_cfg,
    output bgt_pkg::t_btn_res             o_res
);
    logic                       r_stable, n_stable;
    logic [bgt_pkg::TIME_W-1:0] r_edge_time, n_edge_time;
    logic [bgt_pkg::TIME_W-1:0] r_press_time, n_press_time;
    logic                       r_long_fired, n_long_fired;

    logic [bgt_pkg::TIME_W-1:0] since_edge, since_press, since_new_press;
    logic                       edge_ok, long_hit;

    always_comb begin
        since_edge   = i_now - r_edge_time;
        since_press  = i_now - r_press_time;
        edge_ok      = (i_level != r_stable) &&
                       (since_edge >= {16'd0, i_cfg.settle_ms});
        n_stable     = edge_ok ? i_level : r_stable;
        n_edge_time  = edge_ok ? i_now : r_edge_time;
        n_press_time = (edge_ok && i_level) ? i_now : r_press_time;
        since_new_press = i_now - n_press_time;
        long_hit     = n_stable && !((edge_ok && i_level) ? 1'b0 : r_long_fired) &&
                       (since_new_press >= {16'd0, i_cfg.long_press_ms});
        n_long_fired = long_hit ? 1'b1 :
                       ((edge_ok && i_level) ? 1'b0 : r_long_fired);

        o_res.short_press = edge_ok && !i_level &&
                            (since_press < {16'd0, i_cfg.long_press_ms});
        o_res.long_press  = long_hit;
        o_res.button_down = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable     <= 1'b0;
            r_edge_time  <= '0;
            r_press_time <= '0;
            r_long_fired <= 1'b0;
        end else if (i_adv) begin
            r_stable     <= n_stable;
            r_edge_time  <= n_edge_time;
            r_press_time <= n_press_time;
            r_long_fired <= n_long_fired;
        end
    end
endmodule

### hw/rtl/bgt_touch.sv
// Touch tracking: finger down, start and last point, release and gesture class.
`timescale 1ns / 1ps

module bgt_touch #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [bgt_pkg::TIME_W-1:0]    i_now,
    input  logic [1:0]                    i_kind,
    input  logic [COORD_WIDTH-1:0]        i_x,
    input  logic [COORD_WIDTH-1:0]        i_y,
    input  bgt_pkg::t_cfg                 i_cfg,
    output bgt_pkg::t_touch_flags         o_flags,
    output logic [COORD_WIDTH-1:0]        o_cur_x,
    output logic [COORD_WIDTH-1:0]        o_cur_y,
    output logic [COORD_WIDTH-1:0]        o_org_x,
    output logic [COORD_WIDTH-1:0]        o_org_y,
    output logic [bgt_pkg::TIME_W-1:0]    o_hold_ms
);
    // compare width covers 2*|dy| and the 12-bit pixel limits
    localparam int CMP_W = ((COORD_WIDTH > 12) ? COORD_WIDTH : 12) + 2;

    logic                       r_finger, n_finger;
    logic [bgt_pkg::TIME_W-1:0] r_start, n_start;
    logic [bgt_pkg::TIME_W-1:0] r_last, n_last;
    logic [COORD_WIDTH-1:0]     r_org_x, n_org_x, r_org_y, n_org_y;
    logic [COORD_WIDTH-1:0]     r_cur_x, n_cur_x, r_cur_y, n_cur_y;

    logic                       is_point, is_lift, quiet, release_now, began;
    logic signed [COORD_WIDTH:0] dx, dy;
    logic [COORD_WIDTH-1:0]     adx, ady;
    logic [CMP_W-1:0]           adx_e, ady_e, ady2_e, tap_e, swipe_e;
    logic [bgt_pkg::TIME_W-1:0] held;
    logic                       is_swipe, is_tap;

    always_comb begin
        is_point    = (i_kind == bgt_pkg::KIND_POINT);
        is_lift     = (i_kind == bgt_pkg::KIND_NOFINGER);
        quiet       = ((i_now - r_last) >= {16'd0, i_cfg.release_quiet_ms});
        release_now = !is_point && r_finger && (is_lift || quiet);
        began       = is_point && !r_finger;

        dx  = $signed({1'b0, r_cur_x}) - $signed({1'b0, r_org_x});
        dy  = $signed({1'b0, r_cur_y}) - $signed({1'b0, r_org_y});
        adx = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : dx[COORD_WIDTH-1:0];
        ady = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : dy[COORD_WIDTH-1:0];
        adx_e   = CMP_W'(adx);
        ady_e   = CMP_W'(ady);
        ady2_e  = CMP_W'({ady, 1'b0});
        tap_e   = CMP_W'(i_cfg.tap_span_px);
        swipe_e = CMP_W'(i_cfg.swipe_reach_px);
        held    = i_now - r_start;

        // swipe wins over tap
        is_swipe = (adx_e >= swipe_e) && (adx_e > ady2_e) &&
                   (held < {16'd0, i_cfg.swipe_max_ms});
        is_tap   = (adx_e <= tap_e) && (ady_e <= tap_e) &&
                   (held < {16'd0, i_cfg.tap_max_ms});

        n_finger = is_point ? 1'b1 : (release_now ? 1'b0 : r_finger);
        n_start  = began ? i_now : r_start;
        n_last   = is_point ? i_now : r_last;
        n_org_x  = began ? i_x : r_org_x;
        n_org_y  = began ? i_y : r_org_y;
        n_cur_x  = is_point ? i_x : r_cur_x;
        n_cur_y  = is_point ? i_y : r_cur_y;

        o_flags.touch_began    = began;
        o_flags.touch_ended    = release_now;
        o_flags.finger_present = n_finger;
        if (!release_now) begin
            o_flags.gesture = bgt_pkg::GEST_NONE;
        end else if (is_swipe) begin
            o_flags.gesture = dx[COORD_WIDTH] ? bgt_pkg::GEST_SWIPE_LEFT
                                              : bgt_pkg::GEST_SWIPE_RIGHT;
        end else if (is_tap) begin
            o_flags.gesture = bgt_pkg::GEST_TAP;
        end else begin
            o_flags.gesture = bgt_pkg::GEST_NONE;
        end

        o_cur_x   = n_cur_x;
        o_cur_y   = n_cur_y;
        o_org_x   = n_org_x;
        o_org_y   = n_org_y;
        o_hold_ms = n_finger ? (i_now - n_start) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finger <= 1'b0;
            r_start  <= '0;
            r_last   <= '0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
        end else if (i_adv) begin
            r_finger <= n_finger;
            r_start  <= n_start;
            r_last   <= n_last;
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
        end
    end
endmodule

### verif/bgt_poll_checker.sv
// Scoreboard for the gesture tracker: predicts each poll result and compares it.
`timescale 1ns / 1ps

module bgt_poll_checker
    import bgt_pkg::*;
#(
    parameter int CW = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgt_in_if                     i_poll,
    bgt_out_if                    i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic              short_press;
        logic              long_press;
        logic              button_down;
        logic              touch_began;
        logic              touch_ended;
        t_gesture          gesture;
        logic              finger_present;
        logic [CW-1:0]     cur_x;
        logic [CW-1:0]     cur_y;
        logic [CW-1:0]     origin_x;
        logic [CW-1:0]     origin_y;
        logic [TIME_W-1:0] hold_ms;
    } t_poll_res;

    t_cfg              cfg;
    logic              btn_q;
    logic              long_done;
    logic              finger_q;
    logic [TIME_W-1:0] btn_edge_t;
    logic [TIME_W-1:0] btn_press_t;
    logic [TIME_W-1:0] touch_t0;
    logic [TIME_W-1:0] last_pt_t;
    logic [CW-1:0]     org_x, org_y, pos_x, pos_y;
    t_poll_res         expected_q[$];
    int                mismatches = 0;
    int                results_seen = 0;

    // Advances the tracker state by one poll and returns the result it causes.
    function automatic t_poll_res track_poll(input logic [TIME_W-1:0] now,
                                             input logic lvl,
                                             input logic [1:0] kind,
                                             input logic [CW-1:0] x,
                                             input logic [CW-1:0] y);
        t_poll_res         r;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_point;
        logic [TIME_W-1:0] held;
        logic              release_now;
        int                dx, dy, adx, ady;
        r = '0;
        r.gesture = GEST_NONE;

        since_edge = now - btn_edge_t;
        if (lvl != btn_q && since_edge >= cfg.settle_ms) begin
            btn_edge_t = now;
            btn_q = lvl;
            if (lvl) begin
                btn_press_t = now;
                long_done = 1'b0;
            end else begin
                since_press = now - btn_press_t;
                if (since_press < cfg.long_press_ms)
                    r.short_press = 1'b1;
            end
        end
        since_press = now - btn_press_t;
        if (btn_q && !long_done && since_press >= cfg.long_press_ms) begin
            long_done = 1'b1;
            r.long_press = 1'b1;
        end

        release_now = 1'b0;
        if (kind == KIND_POINT) begin
            last_pt_t = now;
            if (!finger_q) begin
                finger_q = 1'b1;
                touch_t0 = now;
                org_x = x;
                org_y = y;
                r.touch_began = 1'b1;
            end
            pos_x = x;
            pos_y = y;
        end else if (kind == KIND_NOFINGER) begin
            release_now = finger_q;
        end else begin
            // code 3 behaves as no report
            since_point = now - last_pt_t;
            release_now = finger_q && since_point >= cfg.release_quiet_ms;
        end

        if (release_now) begin
            dx = int'(pos_x) - int'(org_x);
            dy = int'(pos_y) - int'(org_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            held = now - touch_t0;
            finger_q = 1'b0;
            r.touch_ended = 1'b1;
            if (adx >= int'(cfg.swipe_reach_px) && adx > 2 * ady && held < cfg.swipe_max_ms)
                r.gesture = (dx < 0) ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
            else if (adx <= int'(cfg.tap_span_px) && ady <= int'(cfg.tap_span_px) &&
                     held < cfg.tap_max_ms)
                r.gesture = GEST_TAP;
        end

        r.button_down    = btn_q;
        r.finger_present = finger_q;
        r.cur_x          = pos_x;
        r.cur_y          = pos_y;
        r.origin_x       = org_x;
        r.origin_y       = org_y;
        r.hold_ms        = finger_q ? now - touch_t0 : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s got %0h, expected %0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_poll_res want;
        if (!i_rst_n) begin
            cfg.settle_ms        = RST_SETTLE_MS;
            cfg.long_press_ms    = RST_LONG_PRESS_MS;
            cfg.tap_span_px      = RST_TAP_SPAN_PX;
            cfg.swipe_reach_px   = RST_SWIPE_REACH_PX;
            cfg.release_quiet_ms = RST_RELEASE_QUIET_MS;
            cfg.swipe_max_ms     = RST_SWIPE_MAX_MS;
            cfg.tap_max_ms       = RST_TAP_MAX_MS;
            btn_q       = 1'b0;
            long_done   = 1'b0;
            finger_q    = 1'b0;
            btn_edge_t  = '0;
            btn_press_t = '0;
            touch_t0    = '0;
            last_pt_t   = '0;
            org_x       = '0;
            org_y       = '0;
            pos_x       = '0;
            pos_y       = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SETTLE_MS:        cfg.settle_ms        = i_cfg_data;
                    CFG_LONG_PRESS_MS:    cfg.long_press_ms    = i_cfg_data;
                    CFG_TAP_SPAN_PX:      cfg.tap_span_px      = i_cfg_data[11:0];
                    CFG_SWIPE_REACH_PX:   cfg.swipe_reach_px   = i_cfg_data[11:0];
                    CFG_RELEASE_QUIET_MS: cfg.release_quiet_ms = i_cfg_data;
                    CFG_SWIPE_MAX_MS:     cfg.swipe_max_ms     = i_cfg_data;
                    CFG_TAP_MAX_MS:       cfg.tap_max_ms       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_poll.valid && i_poll.ready)
                expected_q.push_back(track_poll(i_poll.now_ms, i_poll.button_level,
                                                i_poll.touch_kind, i_poll.touch_x,
                                                i_poll.touch_y));
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", '0, '0);
                end else begin
                    want = expected_q.pop_front();
                    check_field("short_press", i_res.short_press, want.short_press);
                    check_field("long_press", i_res.long_press, want.long_press);
                    check_field("button_down", i_res.button_down, want.button_down);
                    check_field("touch_began", i_res.touch_began, want.touch_began);
                    check_field("touch_ended", i_res.touch_ended, want.touch_ended);
                    check_field("gesture", i_res.gesture, want.gesture);
                    check_field("finger_present", i_res.finger_present, want.finger_present);
                    check_field("cur_x", i_res.cur_x, want.cur_x);
                    check_field("cur_y", i_res.cur_y, want.cur_y);
                    check_field("origin_x", i_res.origin_x, want.origin_x);
                    check_field("origin_y", i_res.origin_y, want.origin_y);
                    check_field("hold_ms", i_res.hold_ms, want.hold_ms);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### verif/tb_button_and_touch_gesture_tracker.sv
// Testbench top for the gesture tracker: poll stimulus, config phases and verdict.
`timescale 1ns / 1ps

module tb_button_and_touch_gesture_tracker;
    import bgt_pkg::*;

    localparam int         CW              = 12;
    localparam int         COORD_MAX       = (1 << CW) - 1;
    // touch kind code the block must treat like "no report"
    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         NUM_PHASES      = 6;
    localparam int         ITEMS_PER_PHASE = 125;
    // long enough to fill the input and result registers and back up the poll side
    localparam int         HOLD_OFF_CYCLES = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    chk_fail_count;
    int                    chk_pending;

    bgt_in_if  #(.COORD_WIDTH(CW)) poll_if ();
    bgt_out_if #(.COORD_WIDTH(CW)) res_if ();

    button_and_touch_gesture_tracker #(.COORD_WIDTH(CW)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (poll_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Scoreboard sits beside the block and only watches; it reports a failure
    // count and the number of results still outstanding.
    bgt_poll_checker #(.CW(CW)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll       (poll_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls at stall_pct, plus a one-shot hold-off.
    // The stimulus posts a cycle count in hold_off_req; this process owns
    // the countdown so the hold-off is measured in clock cycles.
    // ------------------------------------------------------------------
    int stall_pct    = 0;
    int hold_off_req = 0;
    int hold_left    = 0;

    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_left = hold_off_req;
            hold_off_req <= 0;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Poll side state: a running millisecond clock, the raw button level
    // and the register set currently loaded (to aim gestures at thresholds).
    // ------------------------------------------------------------------
    logic [31:0] now_q;
    logic        btn_raw;
    int          items_sent;
    int          src_idle_pct;
    t_cfg        cur_cfg;
    int          time_scale;

    function automatic logic [CW-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return CW'(COORD_MAX);
        return CW'(v);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, COORD_MAX));
    endfunction

    // Offers one item and returns at the edge that accepts it. Idle cycles
    // go in front with valid low; valid stays high back to back otherwise.
    task automatic send_poll(input logic [31:0] t, input logic lvl, input logic [1:0] kind,
                             input logic [CW-1:0] x, input logic [CW-1:0] y);
        while ($urandom_range(99) < src_idle_pct) begin
            poll_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        poll_if.valid        <= 1'b1;
        poll_if.now_ms       <= t;
        poll_if.button_level <= lvl;
        poll_if.touch_kind   <= kind;
        poll_if.touch_x      <= x;
        poll_if.touch_y      <= y;
        do @(posedge i_clk); while (!poll_if.ready);
        items_sent++;
    endtask

    // One poll tick in the random part: the clock moves mostly in small
    // steps relative to the loaded thresholds, sometimes past them, and
    // rarely jumps anywhere (which also exercises the 32-bit wrap).
    // The button toggles now and then and glitches for single polls.
    task automatic poll(input logic [1:0] kind, input int x, input int y);
        int unsigned r;
        logic        lvl;
        r = $urandom_range(99);
        if (r < 55)
            now_q += $urandom_range(0, time_scale / 8 + 1);
        else if (r < 88)
            now_q += $urandom_range(0, time_scale);
        else if (r < 98)
            now_q += $urandom_range(time_scale, 3 * time_scale);
        else
            now_q += $urandom;
        r = $urandom_range(99);
        if (r < 7)
            btn_raw = ~btn_raw;
        lvl = (r >= 7 && r < 11) ? ~btn_raw : btn_raw;
        send_poll(now_q, lvl, kind, clamp_coord(x), clamp_coord(y));
    endtask

    task automatic poll_noise();
        repeat ($urandom_range(1, 4))
            poll(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
    endtask

    // A well-formed touch: finger down, a few points moving from origin to an
    // end point, then a lift (no-finger packet or quiet polls) or no lift at
    // all so the next touch continues it.
    task automatic run_gesture();
        int ox, oy, ex, ey, span, npts, den, style, ending;
        style = int'($urandom_range(99));
        ox = rand_coord();
        oy = rand_coord();
        if (style < 30) begin
            // inside or just outside the tap box
            span = int'(cur_cfg.tap_span_px) + 1;
            ex = ox + int'($urandom_range(0, 2 * span)) - span;
            ey = oy + int'($urandom_range(0, 2 * span)) - span;
        end else if (style < 70) begin
            // horizontal move left or right around the swipe minimum; the vertical part
            // is usually near half of it to hit the 2:1 slope limit
            span = int'(cur_cfg.swipe_reach_px) + int'($urandom_range(0, 4)) - 2;
            if (span < 0)
                span = 0;
            ex = ($urandom_range(1) != 0) ? ox + span : ox - span;
            ey = ($urandom_range(3) != 0) ? span / 2 + int'($urandom_range(0, 2)) - 1
                                          : int'($urandom_range(0, span / 4 + 1));
            ey = ($urandom_range(1) != 0) ? oy + ey : oy - ey;
        end else if (style < 80) begin
            // edge to edge, the only way to reach the largest swipe minimum
            ox = ($urandom_range(1) != 0) ? 0 : COORD_MAX;
            ex = COORD_MAX - ox;
            ey = oy + int'($urandom_range(0, 8)) - 4;
        end else begin
            ex = rand_coord();
            ey = rand_coord();
        end

        npts = int'($urandom_range(1, 6));
        den = (npts > 1) ? npts - 1 : 1;
        for (int i = 0; i < npts; i++) begin
            if ($urandom_range(99) < 15)
                poll(KIND_NONE, rand_coord(), rand_coord());
            poll(KIND_POINT, ox + (ex - ox) * i / den, oy + (ey - oy) * i / den);
        end

        ending = int'($urandom_range(99));
        if (ending < 45)
            poll(KIND_NOFINGER, rand_coord(), rand_coord());
        else if (ending < 80)
            repeat ($urandom_range(1, 4))
                poll((ending < 65) ? KIND_NONE : KIND_UNUSED, rand_coord(), rand_coord());
    endtask

    // Stops offering and waits for every outstanding result, then lets the
    // pipeline settle.
    task automatic drain();
        poll_if.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        write_reg(CFG_SETTLE_MS, c.settle_ms);
        write_reg(CFG_LONG_PRESS_MS, c.long_press_ms);
        write_reg(CFG_TAP_SPAN_PX, CFG_DATA_W'(c.tap_span_px));
        write_reg(CFG_SWIPE_REACH_PX, CFG_DATA_W'(c.swipe_reach_px));
        write_reg(CFG_RELEASE_QUIET_MS, c.release_quiet_ms);
        write_reg(CFG_SWIPE_MAX_MS, c.swipe_max_ms);
        write_reg(CFG_TAP_MAX_MS, c.tap_max_ms);
        cfg_we <= 1'b0;
        cur_cfg = c;
        // time steps follow the largest time threshold but the settle time so each one gets crossed
        time_scale = int'(c.long_press_ms);
        if (int'(c.release_quiet_ms) > time_scale)
            time_scale = int'(c.release_quiet_ms);
        if (int'(c.swipe_max_ms) > time_scale)
            time_scale = int'(c.swipe_max_ms);
        if (int'(c.tap_max_ms) > time_scale)
            time_scale = int'(c.tap_max_ms);
        time_scale = time_scale / 2 + 16;
    endtask

    // Register sets per phase: reset values, all zero, all ones, tight
    // random, full-range random, and all set to one.
    function automatic t_cfg phase_cfg(input int ph);
        t_cfg c;
        case (ph)
            1: c = '0;
            2: c = '1;
            3: begin
                c.settle_ms        = 16'($urandom_range(0, 100));
                c.long_press_ms    = 16'($urandom_range(0, 2000));
                c.tap_span_px      = 12'($urandom_range(0, 200));
                c.swipe_reach_px   = 12'($urandom_range(0, 600));
                c.release_quiet_ms = 16'($urandom_range(0, 400));
                c.swipe_max_ms     = 16'($urandom_range(0, 2000));
                c.tap_max_ms       = 16'($urandom_range(0, 1500));
            end
            4: begin
                c.settle_ms        = 16'($urandom);
                c.long_press_ms    = 16'($urandom);
                c.tap_span_px      = 12'($urandom);
                c.swipe_reach_px   = 12'($urandom);
                c.release_quiet_ms = 16'($urandom);
                c.swipe_max_ms     = 16'($urandom);
                c.tap_max_ms       = 16'($urandom);
            end
            5: begin
                c.settle_ms        = 16'd1;
                c.long_press_ms    = 16'd1;
                c.tap_span_px      = 12'd1;
                c.swipe_reach_px   = 12'd1;
                c.release_quiet_ms = 16'd1;
                c.swipe_max_ms     = 16'd1;
                c.tap_max_ms       = 16'd1;
            end
            default: begin
                c.settle_ms        = RST_SETTLE_MS;
                c.long_press_ms    = RST_LONG_PRESS_MS;
                c.tap_span_px      = RST_TAP_SPAN_PX;
                c.swipe_reach_px   = RST_SWIPE_REACH_PX;
                c.release_quiet_ms = RST_RELEASE_QUIET_MS;
                c.swipe_max_ms     = RST_SWIPE_MAX_MS;
                c.tap_max_ms       = RST_TAP_MAX_MS;
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   phase_end;
        logic paused;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_SETTLE_MS;
        cfg_data             = '0;
        poll_if.valid        = 1'b0;
        poll_if.now_ms       = '0;
        poll_if.button_level = 1'b0;
        poll_if.touch_kind   = KIND_NONE;
        poll_if.touch_x      = '0;
        poll_if.touch_y      = '0;
        res_if.ready         = 1'b0;
        now_q                = '0;
        btn_raw              = 1'b0;
        items_sent           = 0;
        src_idle_pct         = 0;
        paused               = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed polls on the reset register values.
        load_cfg(phase_cfg(0));
        // nothing happening; unused kind and a no-finger packet with no finger down
        send_poll(32'd0, 1'b0, KIND_NONE, '0, '0);
        send_poll(32'd1, 1'b0, KIND_UNUSED, 12'hFFF, 12'hFFF);
        send_poll(32'd2, 1'b0, KIND_NOFINGER, 12'hAAA, 12'h555);
        // press inside the debounce window is rejected, then accepted
        send_poll(32'd10, 1'b1, KIND_NONE, 12'h555, 12'hAAA);
        send_poll(32'd50, 1'b1, KIND_NONE, '0, '0);
        // bounce on release, then a short press
        send_poll(32'd60, 1'b0, KIND_NONE, '0, '0);
        send_poll(32'd200, 1'b0, KIND_NONE, '0, '0);
        // hold to exactly the long time: fires once, no short press on release
        send_poll(32'd300, 1'b1, KIND_NONE, '0, '0);
        send_poll(32'd1100, 1'b1, KIND_NONE, '0, '0);
        send_poll(32'd1500, 1'b1, KIND_NONE, '0, '0);
        send_poll(32'd1600, 1'b0, KIND_NONE, '0, '0);
        // full-width swipe right, ended by a no-finger packet
        send_poll(32'd2000, 1'b0, KIND_POINT, 12'd0, 12'd0);
        send_poll(32'd2050, 1'b0, KIND_POINT, 12'hFFF, 12'd0);
        send_poll(32'd2100, 1'b0, KIND_NOFINGER, '0, '0);
        // swipe left from the far corner
        send_poll(32'd2200, 1'b0, KIND_POINT, 12'hFFF, 12'hFFF);
        send_poll(32'd2250, 1'b0, KIND_POINT, 12'd4000, 12'd4090);
        send_poll(32'd2300, 1'b0, KIND_NOFINGER, '0, '0);
        // tap ended by the quiet timeout, first poll still inside the window
        send_poll(32'd2400, 1'b0, KIND_POINT, 12'd100, 12'd100);
        send_poll(32'd2410, 1'b0, KIND_POINT, 12'd110, 12'd90);
        send_poll(32'd2460, 1'b0, KIND_NONE, '0, '0);
        send_poll(32'd2600, 1'b0, KIND_UNUSED, '0, '0);
        // vertical move: neither swipe nor tap
        send_poll(32'd2700, 1'b0, KIND_POINT, 12'd2048, 12'd2048);
        send_poll(32'd2710, 1'b0, KIND_POINT, 12'd2048, 12'd3000);
        send_poll(32'd2720, 1'b0, KIND_NOFINGER, '0, '0);
        // touch spanning the 32-bit wrap of the clock
        send_poll(32'hFFFF_FFFF, 1'b0, KIND_POINT, 12'd5, 12'd5);
        send_poll(32'h0000_0010, 1'b0, KIND_NOFINGER, '0, '0);
        drain();
        now_q = 32'h0000_0100;

        // Random phases, each with its own register set and idle pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_cfg(phase_cfg(ph));
            case (ph % 4)
                0: begin src_idle_pct = 0;  stall_pct <= 0;  end
                1: begin src_idle_pct = 57; stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  stall_pct <= 57; end
                default: begin src_idle_pct = 29; stall_pct <= 29; end
            endcase
            // long result stall while polls keep coming: back-pressure check
            if (ph == 0)
                hold_off_req <= HOLD_OFF_CYCLES;
            // start some phases just below the wrap point
            if (ph % 2 == 1)
                now_q = 32'hFFFF_FFFF - $urandom_range(0, 4 * time_scale);
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 75)
                    run_gesture();
                else
                    poll_noise();
                // once, stop mid-phase until everything outstanding has come back
                if (ph == 2 && !paused && items_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        if (chk_fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bgt_pkg.sv
hw/rtl/bgt_in_if.sv
hw/rtl/bgt_out_if.sv
hw/rtl/bgt_cfg_regs.sv
hw/rtl/bgt_button.sv
hw/rtl/bgt_touch.sv
hw/rtl/button_and_touch_gesture_tracker.sv
verif/bgt_poll_checker.sv
verif/tb_button_and_touch_gesture_tracker.sv
